>>> design/assert_macros.svh
// Assertion helpers used by the checker file tdf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tdf_pkg.sv
package tdf_pkg;

    localparam int PRIME_W = 32;
    localparam int EXP_W   = 5;
    localparam int TAG_W   = 8;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exponent;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } tdf_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIV,
        ST_EVAL,
        ST_EMIT_D,
        ST_EMIT_REM
    } tdf_state_t;

endpackage

>>> design/tdf_if.sv
interface tdf_in_if
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [TAG_W-1:0]       item_tag;

    modport source (output valid, output value, output item_tag, input ready);
    modport sink   (input valid, input value, input item_tag, output ready);
endinterface

interface tdf_out_if
    import tdf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PRIME_W-1:0] factor_prime;
    logic [EXP_W-1:0]   exponent;
    logic [TAG_W-1:0]   tag_out;
    logic               last;

    modport source (output valid, output factor_prime, output exponent,
                    output tag_out, output last, input ready);
    modport sink   (input valid, input factor_prime, input exponent,
                    input tag_out, input last, output ready);
endinterface

>>> design/trial_division_factorizer.sv
// Trial-division prime factorizer.
//
// values  : one beat carries an unsigned value and an 8-bit tag. Ready is high
//           only while the block is idle; one value is factored at a time.
// factors : one beat per distinct prime, ascending, with its exponent and the
//           echoed tag; last marks the final prime of a value. Values 0 and 1
//           produce no beats.
// Search  : each trial divisor goes through a square check, a divider launch,
//           the bit-serial divide steps and an evaluation; each extra power of
//           a found prime repeats the launch, divide and evaluation. A value
//           needs up to sqrt(value) trial divisors, so small or smooth values
//           finish far sooner than large primes.
// Stall   : results go through a one-entry output register; the search
//           holds only when it has a new prime and that register is still
//           full. A finished value frees the input while its last beat waits.
// Reset   : rst_n is asynchronous, active low; it drops any value in work and
//           any pending beat and returns the block to idle.
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    tdf_in_if.sink    values,
    tdf_out_if.source factors
);

    // Divisors stay at or below the square root, plus one step past it.
    localparam int HALF = (VALUE_WIDTH + 1) / 2;
    localparam int DW   = HALF + 1;
    localparam int SW   = 2 * HALF + 1;

    tdf_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [SW-1:0]          sq_reg, sq_next;
    logic [EXP_W-1:0]       exp_reg, exp_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;

    logic                   accept;
    logic                   sq_fits;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DW-1:0]          div_rem;
    logic                   div_exact;
    logic                   push;
    logic                   can_push;
    tdf_result_t            push_data;

    assign accept    = values.valid && values.ready;
    assign sq_fits   = (sq_reg <= SW'(rem_reg));
    assign div_exact = (div_rem == '0);

    tdf_serial_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    tdf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .factors   (factors)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_fits)
                begin
                    state_next = ST_START;
                end
                else if (rem_reg > VALUE_WIDTH'(1))
                begin
                    state_next = ST_EMIT_REM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // Keep dividing the same divisor out while it divides exactly.
                if (div_exact)
                begin
                    state_next = ST_START;
                end
                else if (exp_reg != '0)
                begin
                    state_next = ST_EMIT_D;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT_D:
            begin
                if (can_push)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT_REM:
            begin
                if (can_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        values.ready = 1'b0;
        div_start    = 1'b0;
        push         = 1'b0;
        push_data    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                values.ready = 1'b1;
            end
            ST_START:
            begin
                div_start = 1'b1;
            end
            ST_EMIT_D:
            begin
                // The divisor is the last prime when nothing is left over.
                push               = 1'b1;
                push_data.prime    = PRIME_W'(d_reg);
                push_data.exponent = exp_reg;
                push_data.tag      = tag_reg;
                push_data.last     = (rem_reg == VALUE_WIDTH'(1));
            end
            ST_EMIT_REM:
            begin
                push               = 1'b1;
                push_data.prime    = PRIME_W'(rem_reg);
                push_data.exponent = EXP_W'(1);
                push_data.tag      = tag_reg;
                push_data.last     = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Datapath: remainder, divisor and its square, exponent count, tag.
    always_comb
    begin
        rem_next = rem_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        exp_next = exp_reg;
        tag_next = tag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next = values.value;
                    tag_next = values.item_tag;
                    d_next   = DW'(2);
                    sq_next  = SW'(4);
                    exp_next = '0;
                end
            end
            ST_EVAL:
            begin
                if (div_exact)
                begin
                    rem_next = div_quot;
                    exp_next = exp_reg + EXP_W'(1);
                end
                else if (exp_reg == '0)
                begin
                    // (d + 1)^2 = d^2 + 2d + 1
                    d_next  = d_reg + DW'(1);
                    sq_next = sq_reg + SW'({d_reg, 1'b1});
                end
            end
            ST_EMIT_D:
            begin
                if (can_push)
                begin
                    exp_next = '0;
                    d_next   = d_reg + DW'(1);
                    sq_next  = sq_reg + SW'({d_reg, 1'b1});
                end
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        tag_reg <= tag_next;
    end

endmodule

>>> design/tdf_serial_div.sv
// Restoring divider, one quotient bit per cycle.
module tdf_serial_div
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIV_WIDTH   = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIV_WIDTH-1:0]   remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [DIV_WIDTH-1:0]   r_reg, r_next;
    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH:0]     diff;
    logic                   busy;
    logic                   fits;

    assign busy  = (cnt_reg != '0);
    assign trial = {r_reg, q_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = busy && (cnt_reg == CW'(1));
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            cnt_next = CW'(VALUE_WIDTH);
            q_next   = dividend;
            r_next   = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CW'(1);
            q_next   = {q_reg[VALUE_WIDTH-2:0], fits};
            r_next   = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> design/tdf_out_reg.sv
// One-entry output register between the search loop and the result channel.
module tdf_out_reg
    import tdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tdf_result_t      push_data,
    output logic             can_push,
    tdf_out_if.source        factors
);

    logic        valid_reg, valid_next;
    tdf_result_t data_reg, data_next;

    assign can_push = !valid_reg || factors.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && factors.ready)
        begin
            valid_next = 1'b0;
        end
        if (push && can_push)
        begin
            valid_next = 1'b1;
            data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign factors.valid        = valid_reg;
    assign factors.factor_prime = data_reg.prime;
    assign factors.exponent     = data_reg.exponent;
    assign factors.tag_out      = data_reg.tag;
    assign factors.last         = data_reg.last;

endmodule

>>> design/tdf_checker.sv
`include "assert_macros.svh"

module tdf_checker
    import tdf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               values_ready,
    input logic               factors_valid,
    input logic               factors_ready,
    input logic [PRIME_W-1:0] factors_prime,
    input logic [EXP_W-1:0]   factors_exponent,
    input logic [TAG_W-1:0]   factors_tag,
    input logic               factors_last
);

    // Hold a stalled beat.
    `TDF_ASSERT_NEXT(a_hold_stalled, clk, rst_n, factors_valid && !factors_ready, factors_valid && $stable(factors_prime) && $stable(factors_exponent) && $stable(factors_tag) && $stable(factors_last), "stalled result beat changed")

    // A prime appears at least once and is at least two.
    `TDF_ASSERT_NOW(a_prime_sane, clk, rst_n, factors_valid, (factors_exponent != '0) && (factors_prime > PRIME_W'(1)), "result with zero exponent or prime below two")

    // While a value's factors are still coming, take no new value.
    `TDF_ASSERT_NOW(a_busy_mid_value, clk, rst_n, factors_valid && !factors_last, !values_ready, "input ready before last factor was produced")

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .values_ready     (values.ready),
    .factors_valid    (factors.valid),
    .factors_ready    (factors.ready),
    .factors_prime    (factors.factor_prime),
    .factors_exponent (factors.exponent),
    .factors_tag      (factors.tag_out),
    .factors_last     (factors.last)
);
